### hw/rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg
// types, codes and helpers shared by the cookie header tokenizer
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam int OFS_W = 13;
    localparam int LEN_W = 14;
    localparam int CNT_W = 13;

    localparam logic [CNT_W-1:0] CNT_MAX = 13'h1FFF;

    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int FQ_CW    = FQ_AW + 1;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'd0,
        PH_NAME   = 3'd1,
        PH_VLEAD  = 3'd2,
        PH_QOPEN  = 3'd3,
        PH_UNQ    = 3'd4,
        PH_QVAL   = 3'd5,
        PH_AFTERQ = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        SEP_SEMI  = 2'd0,
        SEP_COMMA = 2'd1,
        SEP_END   = 2'd2
    } t_sep;

    typedef enum logic {
        REC_COOKIE = 1'b0,
        REC_END    = 1'b1
    } t_kind;

    typedef struct packed {
        logic eq;
        logic oq;
        logic cq;
        logic val;
    } t_flags;

    typedef struct packed {
        t_kind             record_kind;
        logic [OFS_W-1:0]  name_offset;
        logic [LEN_W-1:0]  name_length;
        logic              value_present;
        logic [OFS_W-1:0]  value_offset;
        logic [LEN_W-1:0]  value_length;
        logic              equals_seen;
        logic              open_quote_seen;
        logic              close_quote_seen;
        t_sep              separator_kind;
        logic [CNT_W-1:0]  cookie_total;
        logic              length_overflow;
    } t_rec;

    typedef struct packed {
        logic [1:0] cnt;
        t_rec       rec0;
        t_rec       rec1;
    } t_rec_pair;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
    endfunction

endpackage

### hw/rtl/cht_byte_if.sv
// ----------------------------------------------------------------------------
// cht_byte_if
// header byte channel: valid/ready with one byte and a last-byte mark
// ----------------------------------------------------------------------------
interface cht_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] header_byte;
    logic       is_final_byte;

    modport source (output valid, output header_byte, output is_final_byte, input ready);
    modport sink   (input valid, input header_byte, input is_final_byte, output ready);
endinterface

### hw/rtl/cht_rec_if.sv
// ----------------------------------------------------------------------------
// cht_rec_if
// record channel: valid/ready with one cookie or end-of-header record
// ----------------------------------------------------------------------------
interface cht_rec_if;
    logic        valid;
    logic        ready;
    logic        record_kind;
    logic [12:0] name_offset;
    logic [13:0] name_length;
    logic        value_present;
    logic [12:0] value_offset;
    logic [13:0] value_length;
    logic        equals_seen;
    logic        open_quote_seen;
    logic        close_quote_seen;
    logic [1:0]  separator_kind;
    logic [12:0] cookie_total;
    logic        length_overflow;

    modport source (
        output valid, output record_kind, output name_offset, output name_length,
        output value_present, output value_offset, output value_length,
        output equals_seen, output open_quote_seen, output close_quote_seen,
        output separator_kind, output cookie_total, output length_overflow,
        input ready
    );
    modport sink (
        input valid, input record_kind, input name_offset, input name_length,
        input value_present, input value_offset, input value_length,
        input equals_seen, input open_quote_seen, input close_quote_seen,
        input separator_kind, input cookie_total, input length_overflow,
        output ready
    );
endinterface

### hw/rtl/cht_core.sv
// ----------------------------------------------------------------------------
// cht_core
// parse state and per-byte record builder, up to two records per byte
// ----------------------------------------------------------------------------
module cht_core #(
    parameter int MAX_HEADER_BYTES = 8192
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic [7:0]         i_byte,
    input  logic               i_fin,
    output cht_pkg::t_rec_pair o_wr
);
    import cht_pkg::*;

    localparam int POS_W = $clog2(MAX_HEADER_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_HEADER_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_HEADER_BYTES - 1);
    localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);

    t_phase           r_phase;
    logic [POS_W-1:0] r_bpos, r_ns, r_nte, r_vs, r_vte;
    t_flags           r_flags;
    logic [CNT_W-1:0] r_cnt;
    logic             r_ovf;

    logic             ovf_now, n_ovf, sep, ws, is_eq, bc, a_req, a_v, b_v;
    logic [POS_W-1:0] pos, pos1, n_bpos;
    t_sep             sep_c, a_sep, b_sep;
    t_phase           s_phase, t_phase_q;
    logic [POS_W-1:0] s_ns, s_nte, s_vs, s_vte, t_ns, t_nte, t_vs, t_vte;
    t_flags           s_flags, t_flg;
    logic [CNT_W-1:0] cnt_a, cnt_b;
    t_rec             rec_a, rec_b, rec_e;

    function automatic t_rec build_rec(
        input logic [POS_W-1:0] ns,
        input logic [POS_W-1:0] nte,
        input logic [POS_W-1:0] vs,
        input logic [POS_W-1:0] vte,
        input t_flags           fl,
        input t_sep             sp,
        input logic [CNT_W-1:0] total,
        input logic             ovf
    );
        t_rec r;
        r                  = '0;
        r.record_kind      = REC_COOKIE;
        r.name_offset      = OFS_W'(ns);
        r.name_length      = LEN_W'(nte - ns);
        r.value_present    = fl.val;
        r.value_offset     = fl.val ? OFS_W'(vs) : '0;
        r.value_length     = (fl.val && vte > vs) ? LEN_W'(vte - vs) : '0;
        r.equals_seen      = fl.eq;
        r.open_quote_seen  = fl.oq;
        r.close_quote_seen = fl.cq;
        r.separator_kind   = sp;
        r.cookie_total     = total;
        r.length_overflow  = ovf;
        return r;
    endfunction

    always_comb begin
        ovf_now = (r_bpos >= POS_MAX);
        pos     = ovf_now ? POS_LAST : r_bpos;
        pos1    = pos + POS_ONE;
        n_bpos  = ovf_now ? r_bpos : r_bpos + POS_ONE;
        n_ovf   = r_ovf | ovf_now;
        sep     = (i_byte == CH_SEMI) || (i_byte == CH_COMMA);
        sep_c   = (i_byte == CH_SEMI) ? SEP_SEMI : SEP_COMMA;
        ws      = is_ws(i_byte);
        is_eq   = (i_byte == CH_EQ);

        s_phase = r_phase;
        s_ns    = r_ns;
        s_nte   = r_nte;
        s_vs    = r_vs;
        s_vte   = r_vte;
        s_flags = r_flags;
        a_req   = 1'b0;
        a_sep   = sep_c;
        bc      = 1'b0;

        unique case (r_phase)
            PH_NAME: begin
                if (is_eq) begin
                    s_flags.eq = 1'b1;
                    s_phase    = PH_VLEAD;
                end else if (sep) begin
                    a_req   = 1'b1;
                    s_phase = PH_SKIP;
                end else if (!ws) begin
                    s_nte = pos1;
                end
            end
            PH_VLEAD: begin
                if (!ws) begin
                    if (i_byte == CH_QUOTE) begin
                        s_flags.oq = 1'b1;
                        s_phase    = PH_QOPEN;
                    end else begin
                        s_flags.val = 1'b1;
                        s_vs        = pos;
                        if (sep) begin
                            s_vte   = pos;
                            a_req   = 1'b1;
                            s_phase = PH_SKIP;
                        end else begin
                            s_vte   = pos1;
                            s_phase = PH_UNQ;
                        end
                    end
                end
            end
            PH_QOPEN: begin
                s_flags.val = 1'b1;
                s_vs        = pos;
                if (i_byte == CH_QUOTE) begin
                    s_flags.cq = 1'b1;
                    s_vte      = pos;
                    s_phase    = PH_AFTERQ;
                end else begin
                    s_vte   = pos1;
                    s_phase = PH_QVAL;
                end
            end
            PH_QVAL: begin
                if (i_byte == CH_QUOTE) begin
                    s_flags.cq = 1'b1;
                    s_phase    = PH_AFTERQ;
                end else begin
                    s_vte = pos1;
                end
            end
            PH_UNQ: begin
                if (sep) begin
                    a_req   = 1'b1;
                    s_phase = PH_SKIP;
                end else if (!ws) begin
                    s_vte = pos1;
                end
            end
            PH_AFTERQ: begin
                if (!ws) begin
                    a_req = 1'b1;
                    if (sep) begin
                        s_phase = PH_SKIP;
                    end else begin
                        a_sep = SEP_SEMI;
                        bc    = 1'b1;
                    end
                end
            end
            default: begin
                if (!(ws || sep)) begin
                    bc = 1'b1;
                end else begin
                    s_phase = PH_SKIP;
                end
            end
        endcase

        if (bc) begin
            t_flg     = '0;
            t_flg.eq  = is_eq;
            t_vs      = '0;
            t_vte     = '0;
            t_ns      = pos;
            t_nte     = is_eq ? pos : pos1;
            t_phase_q = is_eq ? PH_VLEAD : PH_NAME;
        end else begin
            t_flg     = s_flags;
            t_vs      = s_vs;
            t_vte     = s_vte;
            t_ns      = s_ns;
            t_nte     = s_nte;
            t_phase_q = s_phase;
        end

        a_v   = a_req && (s_nte > s_ns);
        cnt_a = a_v ? cnt_inc(r_cnt) : r_cnt;
        b_v   = i_fin && !a_v && (t_nte > t_ns)
              && (t_phase_q != PH_SKIP) && (t_phase_q <= PH_AFTERQ);
        b_sep = (t_phase_q == PH_AFTERQ) ? SEP_SEMI : SEP_END;
        cnt_b = b_v ? cnt_inc(cnt_a) : cnt_a;

        rec_a = build_rec(s_ns, s_nte, s_vs, s_vte, s_flags, a_sep, cnt_a, n_ovf);
        rec_b = build_rec(t_ns, t_nte, t_vs, t_vte, t_flg, b_sep, cnt_b, n_ovf);

        rec_e                 = '0;
        rec_e.record_kind     = REC_END;
        rec_e.separator_kind  = SEP_END;
        rec_e.cookie_total    = cnt_b;
        rec_e.length_overflow = n_ovf;

        o_wr.cnt  = i_en ? (2'(a_v) + 2'(b_v) + 2'(i_fin)) : 2'd0;
        o_wr.rec0 = a_v ? rec_a : (b_v ? rec_b : rec_e);
        o_wr.rec1 = rec_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_bpos  <= '0;
            r_ns    <= '0;
            r_nte   <= '0;
            r_vs    <= '0;
            r_vte   <= '0;
            r_flags <= '0;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
        end else if (i_en) begin
            if (i_fin) begin
                r_phase <= PH_SKIP;
                r_bpos  <= '0;
                r_ns    <= '0;
                r_nte   <= '0;
                r_vs    <= '0;
                r_vte   <= '0;
                r_flags <= '0;
                r_cnt   <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_phase <= t_phase_q;
                r_bpos  <= n_bpos;
                r_ns    <= t_ns;
                r_nte   <= t_nte;
                r_vs    <= t_vs;
                r_vte   <= t_vte;
                r_flags <= t_flg;
                r_cnt   <= cnt_a;
                r_ovf   <= n_ovf;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_cookie_name_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr.cnt != 2'd0 && o_wr.rec0.record_kind == REC_COOKIE)
            |-> o_wr.rec0.name_length != '0)
        else $error("cookie record with empty name");

    a_pair_ends_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr.cnt == 2'd2)
            |-> (o_wr.rec0.record_kind == REC_COOKIE && o_wr.rec1.record_kind == REC_END
                 && i_fin))
        else $error("two records without a closing end record");

    a_final_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_fin) |=> (r_phase == PH_SKIP && r_bpos == '0 && r_cnt == '0 && !r_ovf))
        else $error("state not cleared after last byte");
`endif
endmodule

### hw/rtl/cht_rec_fifo.sv
// ----------------------------------------------------------------------------
// cht_rec_fifo
// small record queue, up to two writes and one read per cycle
// ----------------------------------------------------------------------------
module cht_rec_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cht_pkg::t_rec_pair i_wr,
    output logic               o_room,
    output logic               o_valid,
    output cht_pkg::t_rec      o_data,
    input  logic               i_ready
);
    import cht_pkg::*;

    t_rec             r_mem [FQ_DEPTH];
    logic [FQ_AW-1:0] r_wptr, r_rptr;
    logic [FQ_CW-1:0] r_count;
    logic [FQ_AW-1:0] wptr1;
    logic             pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_room  = (r_count <= FQ_CW'(FQ_DEPTH - 2));
    assign pop     = o_valid && i_ready;
    assign wptr1   = r_wptr + FQ_AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_wr.cnt != 2'd0) begin
            r_mem[r_wptr] <= i_wr.rec0;
        end
        if (i_wr.cnt == 2'd2) begin
            r_mem[wptr1] <= i_wr.rec1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + FQ_AW'(i_wr.cnt);
            r_rptr  <= r_rptr + FQ_AW'(pop);
            r_count <= r_count + FQ_CW'(i_wr.cnt) - FQ_CW'(pop);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (FQ_CW'(i_wr.cnt) + r_count) <= FQ_CW'(FQ_DEPTH))
        else $error("record queue overrun");

    a_count_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr.cnt == 2'd0 && !pop) |=> $stable(r_count) && $stable(r_rptr))
        else $error("queue moved without traffic");
`endif
endmodule

### hw/rtl/cookie_header_tokenizer.sv
// ----------------------------------------------------------------------------
// cookie_header_tokenizer
// splits a cookie header, fed one byte per word, into cookie records
// ----------------------------------------------------------------------------
// i_hdr takes one header byte per word; is_final_byte marks the last byte.
// o_rec gives one record per word: a cookie record for each cookie with a
// non-empty name, and an end record with the count after the last byte.
// A byte is held in an input register, then parsed combinationally into zero,
// one or two records that go into a four-entry record queue.
// Records of a byte pass through the input register and then the record
// queue; a second record of the same byte leaves the queue after the first.
// Throughput: one byte per cycle while the queue has room; records leave one
// per cycle while o_rec.ready is high. i_hdr.ready drops while the input
// register is full and the queue has fewer than two free entries, so a
// stalled receiver backs up into the byte channel; no record is dropped.
// Reset clears the parser to the start of a new header and empties the
// queue; the next header also starts fresh after each last byte.
// ----------------------------------------------------------------------------
module cookie_header_tokenizer #(
    parameter int MAX_HEADER_BYTES = 8192
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cht_byte_if.sink   i_hdr,
    cht_rec_if.source  o_rec
);
    import cht_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_fin;
    logic       proc, room, take, q_valid;
    t_rec_pair  wr;
    t_rec       q_data;

    assign proc        = r_in_valid && room;
    assign i_hdr.ready = !r_in_valid || proc;
    assign take        = i_hdr.valid && i_hdr.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= i_hdr.header_byte;
            r_fin  <= i_hdr.is_final_byte;
        end
    end

    cht_core #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc),
        .i_byte  (r_byte),
        .i_fin   (r_fin),
        .o_wr    (wr)
    );

    cht_rec_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .o_room  (room),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_ready (o_rec.ready)
    );

    assign o_rec.valid            = q_valid;
    assign o_rec.record_kind      = q_data.record_kind;
    assign o_rec.name_offset      = q_data.name_offset;
    assign o_rec.name_length      = q_data.name_length;
    assign o_rec.value_present    = q_data.value_present;
    assign o_rec.value_offset     = q_data.value_offset;
    assign o_rec.value_length     = q_data.value_length;
    assign o_rec.equals_seen      = q_data.equals_seen;
    assign o_rec.open_quote_seen  = q_data.open_quote_seen;
    assign o_rec.close_quote_seen = q_data.close_quote_seen;
    assign o_rec.separator_kind   = q_data.separator_kind;
    assign o_rec.cookie_total     = q_data.cookie_total;
    assign o_rec.length_overflow  = q_data.length_overflow;
endmodule
